/* rtl/bss_pkg.sv */
// Shared constants, types and state codes of the byte signature scanner.
`default_nettype none

package bss_pkg;

    localparam int MAX_OFFSET = 9;
    localparam int POS_W      = 32;
    localparam int ADDR_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 8;
    localparam int N_STAGE    = 6;
    localparam int LAG        = MAX_OFFSET + 4;
    localparam int WIN        = LAG + 5;
    localparam int FLUSH_W    = $clog2(LAG);
    localparam int CONF_W     = 2;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);

    localparam logic [ADDR_W-1:0] LOAD_BASE_RST = 32'h8C01_0000;

    localparam logic [BYTE_W-1:0] B_E9 = 8'hE9;
    localparam logic [BYTE_W-1:0] B_88 = 8'h88;
    localparam logic [BYTE_W-1:0] B_8D = 8'h8D;
    localparam logic [BYTE_W-1:0] B_DF = 8'hDF;
    localparam logic [BYTE_W-1:0] B_8B = 8'h8B;
    localparam logic [BYTE_W-1:0] B_E4 = 8'hE4;
    localparam logic [BYTE_W-1:0] B_0B = 8'h0B;

    // one flag per signature byte; all clear marks any other byte or a slot outside the stream
    localparam int CLS_W = 7;
    localparam int CL_E9 = 0;
    localparam int CL_88 = 1;
    localparam int CL_8D = 2;
    localparam int CL_DF = 3;
    localparam int CL_8B = 4;
    localparam int CL_E4 = 5;
    localparam int CL_0B = 6;

    localparam int SC_LEAD      = 0;
    localparam int SC_PAIR      = 1;
    localparam int SC_THIRD     = 2;
    localparam int SC_TAIL_STRT = 3;
    localparam int SC_TAIL_PAIR = 4;
    localparam int SC_FULL      = 5;

    localparam logic [CONF_W-1:0] CONF_MAX = 2'd2;

    typedef logic [CLS_W-1:0]            cls_t;
    typedef logic [WIN-1:0][CLS_W-1:0]   win_t;
    typedef logic [N_STAGE-1:0][CNT_W-1:0] cnt_vec_t;

    typedef struct packed {
        win_t             win;
        logic [POS_W-1:0] newest;
        logic             eos;
    } q_entry_t;

    typedef enum logic [1:0] {
        BK_SCAN,
        BK_FLUSH,
        BK_SUMMARY
    } bk_state_t;

endpackage

`default_nettype wire

/* rtl/bss_front.sv */
// Front end: classifies incoming bytes into a shift window and queues snapshots.
`default_nettype none

module bss_front
    import bss_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_data_byte,
    input  wire logic              s_end_of_stream,
    input  wire logic              q_full,
    output logic                   q_push,
    output q_entry_t               q_push_data
);

    win_t             win_reg, win_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    cls_t             cls;
    win_t             win_shift;

    always_comb begin
        cls         = '0;
        cls[CL_E9]  = (s_data_byte == B_E9);
        cls[CL_88]  = (s_data_byte == B_88);
        cls[CL_8D]  = (s_data_byte == B_8D);
        cls[CL_DF]  = (s_data_byte == B_DF);
        cls[CL_8B]  = (s_data_byte == B_8B);
        cls[CL_E4]  = (s_data_byte == B_E4);
        cls[CL_0B]  = (s_data_byte == B_0B);
    end

    assign s_ready   = !q_full;
    assign q_push    = s_valid && s_ready;
    assign win_shift = {win_reg[WIN-2:0], cls};

    assign q_push_data.win    = win_shift;
    assign q_push_data.newest = pos_reg;
    assign q_push_data.eos    = s_end_of_stream;

    always_comb begin
        win_next = win_reg;
        pos_next = pos_reg;
        if (q_push) begin
            if (s_end_of_stream) begin
                win_next = '0;
                pos_next = '0;
            end else begin
                win_next = win_shift;
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
            pos_reg <= '0;
        end else begin
            win_reg <= win_next;
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/bss_queue.sv */
// Short FIFO of window snapshots between the front and back ends.
`default_nettype none

module bss_queue
    import bss_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire q_entry_t push_data,
    input  wire logic     pop,
    output logic          full,
    output logic          empty,
    output q_entry_t      head
);

    q_entry_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]     count_reg, count_next;

    assign full  = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/bss_back.sv */
// Back end: resolves anchors, keeps stage counters and drives the result register.
`default_nettype none

module bss_back
    import bss_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [ADDR_W-1:0] load_base,
    input  wire logic              q_empty,
    input  wire q_entry_t          q_head,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [ADDR_W-1:0]      m_hit_base_address,
    output logic [MAX_OFFSET-1:0]  m_offset_mask,
    output logic [CONF_W-1:0]      m_confirm_count,
    output logic                   m_is_summary,
    output logic [CNT_W-1:0]       m_count_lead,
    output logic [CNT_W-1:0]       m_count_pair,
    output logic [CNT_W-1:0]       m_count_third,
    output logic [CNT_W-1:0]       m_count_tail_start,
    output logic [CNT_W-1:0]       m_count_tail_pair,
    output logic [CNT_W-1:0]       m_count_full,
    output logic                   m_last_of_run
);

    bk_state_t             state_reg, state_next;
    win_t                  wwin_reg, wwin_next;
    logic [FLUSH_W-1:0]    flush_cnt_reg, flush_cnt_next;
    logic [POS_W-1:0]      apos_reg, apos_next;
    cnt_vec_t              cnt_reg, cnt_next, cnt_upd;

    logic                  m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [MAX_OFFSET-1:0] mask_reg, mask_next;
    logic [CONF_W-1:0]     conf_reg, conf_next;
    logic                  summ_reg, summ_next;
    cnt_vec_t              ocnt_reg, ocnt_next;
    logic                  last_reg, last_next;

    logic                  adv;
    logic                  step;
    logic                  emit_anchor;
    logic                  emit_sum;
    win_t                  src_win;
    logic [POS_W-1:0]      src_pos;
    logic                  lead, pair, third;
    logic [MAX_OFFSET-1:0] ts_vec, tp_vec, full_vec;
    logic [CONF_W-1:0]     conf_sum, conf_val;

    assign adv = !m_valid_reg || m_ready;

    // anchor under test always sits at window slot LAG
    always_comb begin
        if (state_reg == BK_SCAN) begin
            src_win = q_head.win;
            src_pos = q_head.newest - POS_W'(LAG);
        end else begin
            src_win = wwin_reg;
            src_pos = apos_reg;
        end
    end

    always_comb begin
        lead  = src_win[LAG][CL_E9];
        pair  = lead & src_win[LAG-1][CL_88];
        third = pair & src_win[LAG-3][CL_8D];
        for (int j = 1; j <= MAX_OFFSET; j++) begin
            ts_vec[j-1]   = third & src_win[LAG-1-j][CL_DF];
            tp_vec[j-1]   = ts_vec[j-1] & src_win[LAG-2-j][CL_88];
            full_vec[j-1] = tp_vec[j-1] & src_win[LAG-4-j][CL_8B];
        end
        conf_sum = CONF_W'(src_win[LAG][CL_0B]) + CONF_W'(src_win[LAG+2][CL_0B])
                 + CONF_W'(src_win[LAG+4][CL_0B]);
        if (!src_win[LAG+1][CL_E4]) begin
            conf_val = '0;
        end else if (conf_sum > CONF_MAX) begin
            conf_val = CONF_MAX;
        end else begin
            conf_val = conf_sum;
        end
    end

    always_comb begin
        cnt_upd               = cnt_reg;
        cnt_upd[SC_LEAD]      = cnt_reg[SC_LEAD] + CNT_W'(lead);
        cnt_upd[SC_PAIR]      = cnt_reg[SC_PAIR] + CNT_W'(pair);
        cnt_upd[SC_THIRD]     = cnt_reg[SC_THIRD] + CNT_W'(third);
        cnt_upd[SC_TAIL_STRT] = cnt_reg[SC_TAIL_STRT] + CNT_W'($countones(ts_vec));
        cnt_upd[SC_TAIL_PAIR] = cnt_reg[SC_TAIL_PAIR] + CNT_W'($countones(tp_vec));
        cnt_upd[SC_FULL]      = cnt_reg[SC_FULL] + CNT_W'($countones(full_vec));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_SCAN: begin
                if (adv && !q_empty && q_head.eos) begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH: begin
                if (adv && flush_cnt_reg == '0) begin
                    state_next = BK_SUMMARY;
                end
            end
            BK_SUMMARY: begin
                if (adv) begin
                    state_next = BK_SCAN;
                end
            end
            default: state_next = BK_SCAN;
        endcase
    end

    // outputs and datapath
    always_comb begin
        step           = 1'b0;
        q_pop          = 1'b0;
        emit_sum       = 1'b0;
        wwin_next      = wwin_reg;
        flush_cnt_next = flush_cnt_reg;
        apos_next      = apos_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        unique case (state_reg)
            BK_SCAN: begin
                step  = adv && !q_empty;
                q_pop = step;
                if (step) begin
                    wwin_next      = {q_head.win[WIN-2:0], CLS_W'(0)};
                    flush_cnt_next = FLUSH_W'(LAG - 1);
                    apos_next      = src_pos + POS_W'(1);
                    last_next      = !q_head.eos;
                end
            end
            BK_FLUSH: begin
                step = adv;
                if (step) begin
                    wwin_next      = {wwin_reg[WIN-2:0], CLS_W'(0)};
                    flush_cnt_next = flush_cnt_reg - 1'b1;
                    apos_next      = apos_reg + POS_W'(1);
                    last_next      = 1'b0;
                end
            end
            BK_SUMMARY: begin
                emit_sum = adv;
                if (emit_sum) begin
                    last_next = 1'b1;
                end
            end
            default: begin
                step = 1'b0;
            end
        endcase
        if (step) begin
            cnt_next = cnt_upd;
        end
        if (emit_sum) begin
            cnt_next = '0;
        end
        emit_anchor = step && (full_vec != '0);
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        addr_next    = addr_reg;
        mask_next    = mask_reg;
        conf_next    = conf_reg;
        summ_next    = summ_reg;
        ocnt_next    = ocnt_reg;
        if (adv) begin
            m_valid_next = emit_anchor || emit_sum;
        end
        if (emit_anchor) begin
            addr_next = load_base + ADDR_W'(src_pos) + ADDR_W'(1);
            mask_next = full_vec;
            conf_next = conf_val;
            summ_next = 1'b0;
            ocnt_next = cnt_upd;
        end else if (emit_sum) begin
            addr_next = '0;
            mask_next = '0;
            conf_next = '0;
            summ_next = 1'b1;
            ocnt_next = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_SCAN;
            flush_cnt_reg <= '0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            flush_cnt_reg <= flush_cnt_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wwin_reg <= wwin_next;
        apos_reg <= apos_next;
        addr_reg <= addr_next;
        mask_reg <= mask_next;
        conf_reg <= conf_next;
        summ_reg <= summ_next;
        ocnt_reg <= ocnt_next;
        if (emit_anchor || emit_sum) begin
            last_reg <= last_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_hit_base_address = addr_reg;
    assign m_offset_mask      = mask_reg;
    assign m_confirm_count    = conf_reg;
    assign m_is_summary       = summ_reg;
    assign m_count_lead       = ocnt_reg[SC_LEAD];
    assign m_count_pair       = ocnt_reg[SC_PAIR];
    assign m_count_third      = ocnt_reg[SC_THIRD];
    assign m_count_tail_start = ocnt_reg[SC_TAIL_STRT];
    assign m_count_tail_pair  = ocnt_reg[SC_TAIL_PAIR];
    assign m_count_full       = ocnt_reg[SC_FULL];
    assign m_last_of_run      = last_reg;

endmodule

`default_nettype wire

/* rtl/byte_signature_scanner.sv */
// Byte signature scanner: top level with the load base register.
// Throughput: one byte per cycle while the queue has room; the back end resolves one anchor
//   per cycle unless stalled; a report resolves from the byte 13 places past its anchor.
// End of stream: the back end flushes the pending anchors, then sends one summary;
//   the 2-transaction queue takes the next bytes until it fills, then the front stalls.
// Reset: synchronous active-low aresetn clears window, position, counters,
//   queue and output valid; load_base returns to 0x8C010000.
`default_nettype none

module byte_signature_scanner
    import bss_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [ADDR_W-1:0] cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_data_byte,
    input  wire logic              s_end_of_stream,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [ADDR_W-1:0]      m_hit_base_address,
    output logic [MAX_OFFSET-1:0]  m_offset_mask,
    output logic [CONF_W-1:0]      m_confirm_count,
    output logic                   m_is_summary,
    output logic [CNT_W-1:0]       m_count_lead,
    output logic [CNT_W-1:0]       m_count_pair,
    output logic [CNT_W-1:0]       m_count_third,
    output logic [CNT_W-1:0]       m_count_tail_start,
    output logic [CNT_W-1:0]       m_count_tail_pair,
    output logic [CNT_W-1:0]       m_count_full,
    output logic                   m_last_of_run
);

    logic [ADDR_W-1:0] load_base_reg, load_base_next;
    logic              q_push, q_pop, q_full, q_empty;
    q_entry_t          q_push_data, q_head;

    assign load_base_next = cfg_wr_en ? cfg_wr_data : load_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_base_reg <= LOAD_BASE_RST;
        end else begin
            load_base_reg <= load_base_next;
        end
    end

    bss_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_stream (s_end_of_stream),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_push_data     (q_push_data)
    );

    bss_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    bss_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .load_base          (load_base_reg),
        .q_empty            (q_empty),
        .q_head             (q_head),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_hit_base_address (m_hit_base_address),
        .m_offset_mask      (m_offset_mask),
        .m_confirm_count    (m_confirm_count),
        .m_is_summary       (m_is_summary),
        .m_count_lead       (m_count_lead),
        .m_count_pair       (m_count_pair),
        .m_count_third      (m_count_third),
        .m_count_tail_start (m_count_tail_start),
        .m_count_tail_pair  (m_count_tail_pair),
        .m_count_full       (m_count_full),
        .m_last_of_run      (m_last_of_run)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("snapshot queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("snapshot queue read while empty");

    a_report_has_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_summary) |-> (m_offset_mask != '0))
        else $error("anchor report without a full hit");

    a_summary_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_summary) |-> (m_last_of_run && m_hit_base_address == '0))
        else $error("summary transaction malformed");

    a_conf_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_confirm_count != 2'd3))
        else $error("confirmation count out of range");

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench for the byte signature scanner: self-checking, random streams with handshake stalls.
`timescale 1ns / 100ps

module tb;
    import bss_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [ADDR_W-1:0]     hit_base;
        logic [MAX_OFFSET-1:0] mask;
        logic [CONF_W-1:0]     conf;
        logic                  summary;
        cnt_vec_t              counts;
        logic                  last;
    } scan_report_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [ADDR_W-1:0]     cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_data_byte = '0;
    logic                  s_end_of_stream = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [ADDR_W-1:0]     m_hit_base_address;
    logic [MAX_OFFSET-1:0] m_offset_mask;
    logic [CONF_W-1:0]     m_confirm_count;
    logic                  m_is_summary;
    logic [CNT_W-1:0]      m_count_lead;
    logic [CNT_W-1:0]      m_count_pair;
    logic [CNT_W-1:0]      m_count_third;
    logic [CNT_W-1:0]      m_count_tail_start;
    logic [CNT_W-1:0]      m_count_tail_pair;
    logic [CNT_W-1:0]      m_count_full;
    logic                  m_last_of_run;

    // scanner model state
    logic [BYTE_W:0]       window_q [WIN];
    logic [POS_W-1:0]      position_q;
    cnt_vec_t              stage_cnt;
    logic [ADDR_W-1:0]     load_base_q;

    scan_report_t          expected_reports [$];
    scan_report_t          step_reports [$];
    logic [BYTE_W-1:0]     stream_buf [$];

    int                    fail_count = 0;
    int                    cycle_count = 0;
    int                    items_sent = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    hold_left = 0;

    byte_signature_scanner i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_end_of_stream    (s_end_of_stream),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_hit_base_address (m_hit_base_address),
        .m_offset_mask      (m_offset_mask),
        .m_confirm_count    (m_confirm_count),
        .m_is_summary       (m_is_summary),
        .m_count_lead       (m_count_lead),
        .m_count_pair       (m_count_pair),
        .m_count_third      (m_count_third),
        .m_count_tail_start (m_count_tail_start),
        .m_count_tail_pair  (m_count_tail_pair),
        .m_count_full       (m_count_full),
        .m_last_of_run      (m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------- model ----------------

    function automatic void clear_stream_state();
        foreach (window_q[k]) window_q[k] = '0;
        position_q = '0;
        stage_cnt  = '0;
    endfunction

    function automatic bit holds(int idx, logic [BYTE_W-1:0] v);
        if (idx < 0 || idx >= WIN)
            return 1'b0;
        return window_q[idx] === {1'b1, v};
    endfunction

    function automatic void resolve_anchor(int t, logic [POS_W-1:0] newest);
        logic [MAX_OFFSET-1:0] hits;
        int                    confirms;
        scan_report_t          rep;
        hits     = '0;
        confirms = 0;
        if (!holds(t, B_E9))
            return;
        stage_cnt[SC_LEAD] += 8'd1;
        if (!holds(t - 1, B_88))
            return;
        stage_cnt[SC_PAIR] += 8'd1;
        if (!holds(t - 3, B_8D))
            return;
        stage_cnt[SC_THIRD] += 8'd1;
        for (int j = 1; j <= MAX_OFFSET; j++) begin
            if (!holds(t - 1 - j, B_DF))
                continue;
            stage_cnt[SC_TAIL_STRT] += 8'd1;
            if (!holds(t - 2 - j, B_88))
                continue;
            stage_cnt[SC_TAIL_PAIR] += 8'd1;
            if (!holds(t - 4 - j, B_8B))
                continue;
            stage_cnt[SC_FULL] += 8'd1;
            hits[j - 1] = 1'b1;
        end
        if (hits == '0)
            return;
        if (holds(t + 1, B_E4)) begin
            if (holds(t, B_0B))
                confirms++;
            if (holds(t + 2, B_0B))
                confirms++;
            if (holds(t + 4, B_0B))
                confirms++;
        end
        rep          = '0;
        rep.hit_base = load_base_q + ADDR_W'(newest - POS_W'(t)) + 1;
        rep.mask     = hits;
        rep.conf     = (confirms > 2) ? CONF_MAX : CONF_W'(confirms);
        rep.counts   = stage_cnt;
        step_reports.push_back(rep);
    endfunction

    function automatic void scan_byte(logic [BYTE_W-1:0] b, logic eos);
        logic [POS_W-1:0] newest;
        scan_report_t     rep;
        newest = position_q;
        for (int k = WIN - 1; k > 0; k--)
            window_q[k] = window_q[k - 1];
        window_q[0] = {1'b1, b};
        position_q  = position_q + 1;
        step_reports.delete();
        resolve_anchor(LAG, newest);
        if (eos) begin
            for (int t = LAG - 1; t >= 0; t--)
                resolve_anchor(t, newest);
            rep         = '0;
            rep.summary = 1'b1;
            rep.counts  = stage_cnt;
            step_reports.push_back(rep);
            clear_stream_state();
        end
        foreach (step_reports[k]) begin
            rep      = step_reports[k];
            rep.last = (k == step_reports.size() - 1);
            expected_reports.push_back(rep);
        end
    endfunction

    // ---------------- checking ----------------

    task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        scan_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected transaction, address %0h", m_hit_base_address);
                fail_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("hit_base_address", want.hit_base, m_hit_base_address);
                check_field("offset_mask", want.mask, m_offset_mask);
                check_field("confirm_count", want.conf, m_confirm_count);
                check_field("is_summary", want.summary, m_is_summary);
                check_field("count_lead", want.counts[SC_LEAD], m_count_lead);
                check_field("count_pair", want.counts[SC_PAIR], m_count_pair);
                check_field("count_third", want.counts[SC_THIRD], m_count_third);
                check_field("count_tail_start", want.counts[SC_TAIL_STRT], m_count_tail_start);
                check_field("count_tail_pair", want.counts[SC_TAIL_PAIR], m_count_tail_pair);
                check_field("count_full", want.counts[SC_FULL], m_count_full);
                check_field("last_of_run", want.last, m_last_of_run);
            end
        end
    end

    // ---------------- driving ----------------

    task automatic send_byte(logic [BYTE_W-1:0] b, logic eos);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_data_byte     <= b;
        s_end_of_stream <= eos;
        do @(posedge aclk); while (!s_ready);
        scan_byte(b, eos);
    endtask

    task automatic send_stream();
        foreach (stream_buf[k])
            send_byte(stream_buf[k], k == stream_buf.size() - 1);
        items_sent += stream_buf.size();
    endtask

    task automatic wait_scanner_idle();
        s_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_load_base(logic [ADDR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        load_base_q = value;
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(9))
            0: return B_E9;
            1: return B_88;
            2: return B_8D;
            3: return B_DF;
            4: return B_8B;
            5: return B_E4;
            6: return B_0B;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    function automatic void put(int idx, logic [BYTE_W-1:0] v);
        if (idx >= 0 && idx < stream_buf.size())
            stream_buf[idx] = v;
    endfunction

    function automatic void plant_signature(int at, int j, bit with_confirm);
        put(at, B_E9);
        put(at + 1, B_88);
        put(at + 3, B_8D);
        put(at + 1 + j, B_DF);
        put(at + 2 + j, B_88);
        put(at + 4 + j, B_8B);
        if (with_confirm) begin
            put(at - 1, B_E4);
            put(at - 2, B_0B);
            put(at - 4, B_0B);
        end
    endfunction

    task automatic send_random_stream();
        int len;
        bit noise;
        len   = ($urandom_range(5) == 0) ? $urandom_range(1, LAG) : $urandom_range(LAG + 1, 60);
        noise = ($urandom_range(4) == 0);
        stream_buf.delete();
        repeat (len)
            stream_buf.push_back(noise ? BYTE_W'($urandom_range(255)) : pick_byte());
        if (!noise)
            repeat ($urandom_range(1, 3))
                plant_signature($urandom_range(0, len - 1), $urandom_range(1, MAX_OFFSET),
                                $urandom_range(1));
        send_stream();
    endtask

    // ---------------- tests ----------------

    // full hits at two offsets, confirmation prefix, anchor resolved by the end flush
    task automatic test_reset_base();
        stream_buf = '{B_0B, 8'h00, B_0B, B_E4, B_E9, B_88, 8'h5A, B_8D,
                       B_DF, B_88, 8'hA5, B_8B, B_DF, B_88, 8'h00, B_8B};
        send_stream();
        wait_scanner_idle();
    endtask

    // one-byte stream: summary only
    task automatic test_single_byte();
        write_load_base('0);
        stream_buf = '{8'hFF};
        send_stream();
        wait_scanner_idle();
    endtask

    // hit at stream byte zero wraps the address; a partial anchor only counts
    task automatic test_address_wrap();
        write_load_base('1);
        stream_buf = '{B_E9, B_88, B_0B, B_8D, B_DF, B_88, 8'h00, B_8B,
                       B_E9, B_88, 8'h00, B_8D, B_DF, 8'h00, 8'hFF};
        send_stream();
        wait_scanner_idle();
    endtask

    // receiver holds off while a hit-dense stream keeps arriving
    task automatic test_back_pressure();
        write_load_base(ADDR_W'($urandom()));
        stream_buf.delete();
        repeat (5) begin
            stream_buf.push_back(B_E9);
            stream_buf.push_back(B_88);
            stream_buf.push_back(BYTE_W'($urandom_range(255)));
            stream_buf.push_back(B_8D);
            stream_buf.push_back(B_DF);
            stream_buf.push_back(B_88);
            stream_buf.push_back(BYTE_W'($urandom_range(255)));
            stream_buf.push_back(B_8B);
        end
        hold_left = HOLD_CYCLES;
        send_stream();
        wait_scanner_idle();
    endtask

    task automatic test_random_streams(logic [ADDR_W-1:0] base, int n_items);
        write_load_base(base);
        items_sent = 0;
        while (items_sent < n_items)
            send_random_stream();
        wait_scanner_idle();
    endtask

    initial begin
        load_base_q = LOAD_BASE_RST;
        clear_stream_state();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 62;
        test_reset_base();
        test_single_byte();
        test_address_wrap();
        test_back_pressure();
        test_random_streams(ADDR_W'($urandom()), 60);

        send_idle_pct = 62;
        recv_idle_pct = 28;
        test_random_streams(32'hFFFF_FFF0, 60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_streams(ADDR_W'($urandom()), 60);

        if (fail_count == 0 && expected_reports.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
